// File: hw/rtl/sspq_pkg.sv
// Package for the stable sorted priority queue.
// Holds the operation and status codes, the entry type and the cell control struct.
// No dependencies; imported by sspq_cell, stable_sorted_priority_queue, sspq_checker and tb_top.
`default_nettype none

package sspq_pkg;

  localparam int PRIO_W  = 8;
  localparam int DATA_W  = 32;
  localparam int SEQ_W   = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_ENQUEUE    = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK_EXACT = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_MIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd4;
  localparam logic [OP_W-1:0] OP_POP_EXACT  = 3'd5;
  localparam logic [OP_W-1:0] OP_POP_MIN    = 3'd6;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd2;

  // Search modes seen by every cell.
  localparam logic [1:0] MODE_FRONT = 2'd0;
  localparam logic [1:0] MODE_EXACT = 2'd1;
  localparam logic [1:0] MODE_MIN   = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  // Control broadcast to all cells for the operation being transferred.
  typedef struct packed {
    logic              enq;
    logic              pop;
    logic [1:0]        mode;
    logic [PRIO_W-1:0] key;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  seq;
  } ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: a chain of DEPTH slot cells.
// Depends on sspq_pkg and sspq_cell.
//
// Usage: an operation (enqueue, peek or pop by front, exact priority or minimum
// threshold) is transferred on the input channel when in_valid is high and
// in_stall is low. Entries stay sorted ascending by priority, and entries of
// equal priority stay in arrival order. Every operation gives exactly one result
// on the output channel, registered, in the cycle after its transfer.
// Throughput is one operation per cycle: all cells compare against the key and
// shift to their neighbor in the same cycle, and the first-match flag ripples
// along the chain. The output register holds one result; while it is full and
// out_stall is high, in_stall is high and no operation is taken.
// Reset empties the queue, clears the sequence counter and drops any held result.
// Slot contents are not cleared; occupancy alone marks which slots are live.
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sspq_pkg::OP_W-1:0]       operation,
  input  wire logic [sspq_pkg::PRIO_W-1:0]     priority_req,
  input  wire logic signed [sspq_pkg::DATA_W-1:0] data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [sspq_pkg::STAT_W-1:0]          status,
  output logic [sspq_pkg::PRIO_W-1:0]          out_priority,
  output logic signed [sspq_pkg::DATA_W-1:0]   out_data,
  output logic [sspq_pkg::SEQ_W-1:0]           out_sequence,
  output logic [sspq_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 queue_empty
);
  import sspq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  logic [SEQ_W-1:0] next_arrival;

  logic             fire;
  logic             full;
  logic             is_search;
  logic             is_pop;
  logic [1:0]       mode;
  logic             found;
  ctl_t             ctl;

  entry_t           ent  [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] sel;
  entry_t           found_ent;

  logic [STAT_W-1:0] status_next;
  entry_t            res_ent;

  // A transfer is taken unless a finished result is held and stalled.
  assign in_stall = out_valid & out_stall;
  assign fire     = in_valid & ~in_stall;
  assign full     = (occupancy == OCC_W'(DEPTH));

  // Operation decode.
  always_comb begin
    unique case (operation)
      OP_ENQUEUE: begin
        is_search = 1'b0; is_pop = 1'b0; mode = MODE_FRONT;
      end
      OP_PEEK_FRONT: begin
        is_search = 1'b1; is_pop = 1'b0; mode = MODE_FRONT;
      end
      OP_PEEK_EXACT: begin
        is_search = 1'b1; is_pop = 1'b0; mode = MODE_EXACT;
      end
      OP_PEEK_MIN: begin
        is_search = 1'b1; is_pop = 1'b0; mode = MODE_MIN;
      end
      OP_POP_FRONT: begin
        is_search = 1'b1; is_pop = 1'b1; mode = MODE_FRONT;
      end
      OP_POP_EXACT: begin
        is_search = 1'b1; is_pop = 1'b1; mode = MODE_EXACT;
      end
      OP_POP_MIN: begin
        is_search = 1'b1; is_pop = 1'b1; mode = MODE_MIN;
      end
      default: begin
        is_search = 1'b0; is_pop = 1'b0; mode = MODE_FRONT;
      end
    endcase
  end

  assign ctl.enq     = fire && (operation == OP_ENQUEUE) && !full;
  assign ctl.pop     = fire && is_pop;
  assign ctl.mode    = mode;
  assign ctl.key     = priority_req;
  assign ctl.payload = $unsigned(data);
  assign ctl.seq     = next_arrival;

  // The cell chain; live slots are the first occupancy cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_gt;
    logic   left_hit;
    entry_t left_ent;
    entry_t right_ent;

    assign valid[i] = (OCC_W'(i) < occupancy);

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_hit = 1'b0;
      assign left_ent = '0;
    end else begin : g_inner
      assign left_gt  = gt[i-1];
      assign left_hit = hit[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    sspq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (valid[i]),
      .left_gt   (left_gt),
      .left_hit  (left_hit),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .gt        (gt[i]),
      .hit       (hit[i]),
      .sel       (sel[i])
    );
  end

  assign found = hit[DEPTH-1];

  // Gather the one selected entry; unselected cells contribute zero.
  always_comb begin
    found_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_ent = found_ent | (sel[i] ? ent[i] : '0);
    end
  end

  // Result and occupancy for the operation being transferred.
  always_comb begin
    occupancy_next = occupancy;
    res_ent        = '0;
    status_next    = ST_NONE;
    if (operation == OP_ENQUEUE) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next    = ST_OK;
        occupancy_next = occupancy + 1'b1;
      end
    end else if (is_search && found) begin
      status_next = ST_OK;
      res_ent     = found_ent;
      if (is_pop) begin
        occupancy_next = occupancy - 1'b1;
      end
    end
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy    <= '0;
      next_arrival <= '0;
    end else if (fire) begin
      occupancy <= occupancy_next;
      if (ctl.enq) begin
        next_arrival <= next_arrival + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= status_next;
      out_priority <= res_ent.prio;
      out_data     <= $signed(res_ent.payload);
      out_sequence <= res_ent.seq;
      entry_count  <= COUNT_W'(occupancy_next);
      queue_empty  <= (occupancy_next == '0);
    end
  end

  // At most one cell is the first match.
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(sel))
    else $error("more than one cell selected as first match");

  // Occupancy never exceeds the chain length.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  // A successful pop removes exactly one entry.
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (fire && is_pop && found) |=> (occupancy == $past(occupancy) - 1'b1))
    else $error("pop did not remove exactly one entry");

  // An accepted enqueue advances the sequence number by one.
  a_seq_inc: assert property (@(posedge clk) disable iff (rst)
    ctl.enq |=> (next_arrival == $past(next_arrival) + 1'b1))
    else $error("sequence number did not advance on enqueue");

endmodule

`default_nettype wire

// File: hw/rtl/sspq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it to or from its neighbors.
// Depends on sspq_pkg for the entry and control types.
`default_nettype none

module sspq_cell (
  input  wire logic            clk,
  input  wire sspq_pkg::ctl_t  ctl,
  input  wire logic            valid,
  input  wire logic            left_gt,
  input  wire logic            left_hit,
  input  wire sspq_pkg::entry_t left_ent,
  input  wire sspq_pkg::entry_t right_ent,
  output sspq_pkg::entry_t     ent,
  output logic                 gt,
  output logic                 hit,
  output logic                 sel
);
  import sspq_pkg::*;

  logic   match;
  entry_t new_ent;

  // Local compare against the broadcast key.
  always_comb begin
    unique case (ctl.mode)
      MODE_FRONT: match = valid;
      MODE_EXACT: match = valid && (ent.prio == ctl.key);
      MODE_MIN:   match = valid && (ent.prio >= ctl.key);
      default:    match = 1'b0;
    endcase
  end

  // The first matching cell is the one with no match to its left.
  assign hit = left_hit | match;
  assign sel = match & ~left_hit;

  // A free cell or a larger priority gives way to the new entry.
  assign gt = ~valid | (ent.prio > ctl.key);

  assign new_ent = '{prio: ctl.key, payload: ctl.payload, seq: ctl.seq};

  // Insert shifts right from the insertion point; removal shifts left into the gap.
  always_ff @(posedge clk) begin
    if (ctl.enq && gt) begin
      ent <= left_gt ? left_ent : new_ent;
    end else if (ctl.pop && hit) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire

// File: tb/sspq_checker.sv
// Checker for the stable sorted priority queue: watches both channels, keeps its own
// sorted copy of the queue and compares every result transfer field by field.
// Depends on sspq_pkg for widths, operation codes, status codes and the entry type.
module sspq_checker #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic                               in_stall,
  input  wire logic [sspq_pkg::OP_W-1:0]          operation,
  input  wire logic [sspq_pkg::PRIO_W-1:0]        priority_req,
  input  wire logic signed [sspq_pkg::DATA_W-1:0] data,
  input  wire logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic [sspq_pkg::STAT_W-1:0]        status,
  input  wire logic [sspq_pkg::PRIO_W-1:0]        out_priority,
  input  wire logic signed [sspq_pkg::DATA_W-1:0] out_data,
  input  wire logic [sspq_pkg::SEQ_W-1:0]         out_sequence,
  input  wire logic [sspq_pkg::COUNT_W-1:0]       entry_count,
  input  wire logic                               queue_empty,
  output int                                      fail_count,
  output int                                      pending,
  output int                                      checked_count,
  output int                                      full_count,
  output int                                      miss_count,
  output int                                      peak_fill
);
  import sspq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PRIO_W-1:0]  prio;
    logic [DATA_W-1:0]  payload;
    logic [SEQ_W-1:0]   seq;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } result_t;

  // Shadow copy of the queue contents, kept sorted like the hardware.
  entry_t           slots [DEPTH];
  int               fill = 0;
  logic [SEQ_W-1:0] arrival_no = '0;

  result_t awaited_results [$];

  int fails = 0;
  int outstanding = 0;
  int checked = 0;
  int fulls = 0;
  int misses = 0;
  int peak = 0;

  assign fail_count    = fails;
  assign pending       = outstanding;
  assign checked_count = checked;
  assign full_count    = fulls;
  assign miss_count    = misses;
  assign peak_fill     = peak;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fails++;
  endtask

  // Index of the first entry that the search mode selects, or -1 when none does.
  function automatic int find_entry(input logic [1:0] mode, input logic [PRIO_W-1:0] key);
    int i;
    for (i = 0; i < fill; i++) begin
      if (mode == MODE_FRONT) return i;
      if (mode == MODE_EXACT && slots[i].prio == key) return i;
      if (mode == MODE_MIN && slots[i].prio >= key) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the shadow queue and work out the result it must give.
  task automatic predict_queue_op(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] key,
                                  input logic [DATA_W-1:0] value, output result_t r);
    int pos;
    int i;
    logic [1:0] mode;
    r = '0;
    r.status = ST_NONE;
    if (op == OP_ENQUEUE) begin
      if (fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Insert after every entry of equal or lower priority to keep arrival order.
        pos = fill;
        while (pos > 0 && slots[pos-1].prio > key) pos--;
        for (i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos] = '{prio: key, payload: value, seq: arrival_no};
        arrival_no = arrival_no + 1'b1;
        fill++;
        r.status = ST_OK;
      end
    end else if (op <= OP_POP_MIN) begin
      if (op == OP_PEEK_FRONT || op == OP_POP_FRONT) mode = MODE_FRONT;
      else if (op == OP_PEEK_EXACT || op == OP_POP_EXACT) mode = MODE_EXACT;
      else mode = MODE_MIN;
      pos = find_entry(mode, key);
      if (pos >= 0) begin
        r.status  = ST_OK;
        r.prio    = slots[pos].prio;
        r.payload = slots[pos].payload;
        r.seq     = slots[pos].seq;
        // Pops close the gap behind the removed entry.
        if (op >= OP_POP_FRONT) begin
          for (i = pos; i < fill - 1; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
    end
    r.count = COUNT_W'(fill);
    r.empty = (fill == 0);
    if (r.status == ST_FULL) fulls++;
    if (r.status == ST_NONE) misses++;
    if (fill > peak) peak = fill;
  endtask

  // Compare result transfers with the oldest prediction, then predict new operations.
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    int delta;
    if (rst) begin
      fill = 0;
      arrival_no = '0;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      delta = 0;
      if (out_valid && !out_stall) begin
        seen = '{status, out_priority, out_data, out_sequence, entry_count, queue_empty};
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with no operation pending, status %0d",
                                    seen.status));
        end else begin
          want = awaited_results.pop_front();
          delta--;
          if (seen.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, wanted %0d",
                                      checked, seen.status, want.status));
          if (seen.prio !== want.prio)
            report_mismatch($sformatf("result %0d: out_priority %0d, wanted %0d",
                                      checked, seen.prio, want.prio));
          if (seen.payload !== want.payload)
            report_mismatch($sformatf("result %0d: out_data %h, wanted %h",
                                      checked, seen.payload, want.payload));
          if (seen.seq !== want.seq)
            report_mismatch($sformatf("result %0d: out_sequence %0d, wanted %0d",
                                      checked, seen.seq, want.seq));
          if (seen.count !== want.count)
            report_mismatch($sformatf("result %0d: entry_count %0d, wanted %0d",
                                      checked, seen.count, want.count));
          if (seen.empty !== want.empty)
            report_mismatch($sformatf("result %0d: queue_empty %0d, wanted %0d",
                                      checked, seen.empty, want.empty));
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_queue_op(operation, priority_req, data, want);
        awaited_results.push_back(want);
        delta++;
      end
      outstanding <= outstanding + delta;
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the stable sorted priority queue: clock, reset, stimulus and verdict.
// Depends on sspq_pkg, the stable_sorted_priority_queue block and the sspq_checker module.
module tb_top;
  import sspq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic [OP_W-1:0]          operation = OP_ENQUEUE;
  logic [PRIO_W-1:0]        priority_req = '0;
  logic signed [DATA_W-1:0] data = '0;
  logic                     out_stall = 1'b0;

  logic                     in_stall;
  logic                     out_valid;
  logic [STAT_W-1:0]        status;
  logic [PRIO_W-1:0]        out_priority;
  logic signed [DATA_W-1:0] out_data;
  logic [SEQ_W-1:0]         out_sequence;
  logic [COUNT_W-1:0]       entry_count;
  logic                     queue_empty;

  int fail_count;
  int pending;
  int checked_count;
  int full_count;
  int miss_count;
  int peak_fill;

  // Stimulus shaping.
  bit                out_free = 1'b0;
  bit                burst = 1'b0;
  int                stall_left = 0;
  int                op_hist [8];
  logic [PRIO_W-1:0] key_pool [4];

  stable_sorted_priority_queue #(.DEPTH(QDEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .priority_req(priority_req), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_priority(out_priority), .out_data(out_data),
    .out_sequence(out_sequence), .entry_count(entry_count), .queue_empty(queue_empty)
  );

  sspq_checker #(.DEPTH(QDEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .priority_req(priority_req), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_priority(out_priority), .out_data(out_data),
    .out_sequence(out_sequence), .entry_count(entry_count), .queue_empty(queue_empty),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count),
    .full_count(full_count), .miss_count(miss_count), .peak_fill(peak_fill)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: runs of free and stalled cycles, mostly short.
  always @(posedge clk) begin
    int r;
    if (rst || out_free) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 8);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(30, 120);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int enq_pct);
    int r = $urandom_range(0, 99);
    if (r < 2) return OP_UNUSED;
    if (r < 2 + enq_pct) return OP_ENQUEUE;
    case ($urandom_range(0, 5))
      0: return OP_PEEK_FRONT;
      1: return OP_PEEK_EXACT;
      2: return OP_PEEK_MIN;
      3: return OP_POP_FRONT;
      4: return OP_POP_EXACT;
      default: return OP_POP_MIN;
    endcase
  endfunction

  // Keys come mostly from a small pool so that exact and threshold searches hit.
  function automatic logic [PRIO_W-1:0] pick_key();
    int r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return PRIO_W'($urandom_range(0, 255));
    return key_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7FFF_FFFF;
    if (r < 8) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // Present one operation and hold it until its transfer, then maybe leave a gap.
  task automatic issue(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] key,
                       input logic [DATA_W-1:0] value);
    int gap;
    operation <= op;
    priority_req <= key;
    data <= value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_hist[op]++;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has been transferred.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    int len;
    int enq_pct;
    int issued;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: searches on an empty queue and the unused code.
    issue(OP_POP_FRONT, 8'd0, 32'd0);
    issue(OP_PEEK_MIN, 8'd0, 32'd0);
    issue(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);

    // Directed: fill to capacity with extreme priorities, ties and payloads.
    issue(OP_ENQUEUE, 8'd0, 32'h8000_0000);
    issue(OP_ENQUEUE, 8'hFF, 32'h7FFF_FFFF);
    issue(OP_ENQUEUE, 8'hFF, 32'hFFFF_FFFF);
    issue(OP_ENQUEUE, 8'd128, 32'd0);
    issue(OP_ENQUEUE, 8'd128, 32'h55AA_55AA);
    issue(OP_ENQUEUE, 8'd0, 32'd0);
    for (i = 0; i < QDEPTH - 6; i++) issue(OP_ENQUEUE, PRIO_W'(i * 23), $urandom);

    // Directed: full rejection, then every search kind, starting on a full queue.
    issue(OP_ENQUEUE, 8'd1, 32'h1234_5678);
    issue(OP_PEEK_MIN, 8'hFF, 32'd0);
    issue(OP_PEEK_EXACT, 8'd128, 32'd0);
    issue(OP_POP_EXACT, 8'd128, 32'd0);
    issue(OP_PEEK_EXACT, 8'd7, 32'd0);
    issue(OP_POP_MIN, 8'd200, 32'd0);
    issue(OP_PEEK_FRONT, 8'd0, 32'd0);
    issue(OP_POP_FRONT, 8'd0, 32'd0);
    issue(OP_UNUSED, 8'd0, 32'd0);
    wait_idle();

    // Random episodes: filling, draining and balanced mixes over a narrow key pool.
    issued = 0;
    while (issued < 600) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 75;
        1: enq_pct = 15;
        default: enq_pct = 45;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 4; i++) key_pool[i] = PRIO_W'($urandom_range(0, 255));
      len = $urandom_range(20, 50);
      repeat (len) issue(pick_op(enq_pct), pick_key(), pick_data());
      issued += len;
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    burst = 1'b0;

    // Drain, then watch a quiet output for stray transfers.
    wait_idle();
    out_free <= 1'b1;
    repeat (10) @(posedge clk);

    $display("Covered %0d enqueues, %0d peeks, %0d pops and %0d unused codes",
             op_hist[OP_ENQUEUE],
             op_hist[OP_PEEK_FRONT] + op_hist[OP_PEEK_EXACT] + op_hist[OP_PEEK_MIN],
             op_hist[OP_POP_FRONT] + op_hist[OP_POP_EXACT] + op_hist[OP_POP_MIN],
             op_hist[OP_UNUSED]);
    $display("Checked %0d results: %0d full rejections, %0d empty or no match, peak fill %0d",
             checked_count, full_count, miss_count, peak_fill);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_cell.sv
hw/rtl/stable_sorted_priority_queue.sv
tb/sspq_checker.sv
tb/tb_top.sv
